// File: rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants and controller/datapath types for the bitmap first-fit
// allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int MAP_BYTES_DEF = 128;
    localparam int WORD_BITS     = 32;
    localparam int WORD_IDX_W    = 5;

    localparam logic [1:0] FUNC_SEARCH = 2'd0;
    localparam logic [1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [1:0] FUNC_FREE   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd;
        logic publish;
    } bffa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic go_scan;
        logic go_rmw;
        logic addr_last;
        logic hit;
        logic scan_end;
    } bffa_stat_t;

endpackage

// File: rtl/bffa_req_if.sv
// ----------------------------------------------------------------------------
// bffa_req_if
// Request channel: operation code, range start and length.
// ----------------------------------------------------------------------------
interface bffa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [9:0]  start_bit;
    logic [10:0] run_length;

    modport source (output valid, output func, output start_bit, output run_length,
                    input ready);
    modport sink   (input valid, input func, input start_bit, input run_length,
                    output ready);
endinterface

// File: rtl/bffa_rsp_if.sv
// ----------------------------------------------------------------------------
// bffa_rsp_if
// Response channel: search outcome and range error flag.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [9:0] run_start;
    logic       range_error;

    modport source (output valid, output found, output run_start, output range_error,
                    input ready);
    modport sink   (input valid, input found, input run_start, input range_error,
                    output ready);
endinterface

// File: rtl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: reset clear sweep, word scan for search, read-modify-write
// sweep for allocate/free, and the output register handshake.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  bffa_pkg::bffa_stat_t  st,
    output bffa_pkg::bffa_cmd_t   cmd
);
    import bffa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RMW   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (st.go_scan)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (st.go_rmw)
                    begin
                        state_next = S_RMW;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (st.hit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    if (st.addr_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (st.hit || st.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_RMW:
            begin
                // last write lands during the done cycle
                cmd.rd = 1'b1;
                if (st.addr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// File: rtl/bffa_dp.sv
// ----------------------------------------------------------------------------
// bffa_dp
// Bitmap word memory, request decode, two-stage run-length scan pipeline,
// range mask read-modify-write, and the result registers.
// ----------------------------------------------------------------------------
module bffa_dp #(
    parameter int MAP_BYTES = bffa_pkg::MAP_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bffa_pkg::bffa_cmd_t   cmd,
    output bffa_pkg::bffa_stat_t  st,
    input  logic [1:0]            func,
    input  logic [9:0]            start_bit,
    input  logic [10:0]           run_length,
    output logic                  found,
    output logic [9:0]            run_start,
    output logic                  range_error
);
    import bffa_pkg::*;

    localparam int MAP_BITS = MAP_BYTES * 8;
    localparam int WORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TAIL     = MAP_BITS % WORD_BITS;
    localparam int PW       = (AW + WORD_IDX_W + 1 > 12) ? AW + WORD_IDX_W + 1 : 12;
    localparam logic [AW-1:0] LAST_WORD  = AW'(WORDS - 1);
    localparam logic [15:0]   MAP_BITS_V = 16'(MAP_BITS);

    logic [WORD_BITS-1:0] mem [WORDS];

    // request decode
    logic [11:0] sum;
    logic [11:0] e_last;
    logic        range_bad;
    logic        len_zero;
    logic        len_big;
    logic        is_rmw;

    // control registers
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] last_reg, last_next;
    logic          rmw_reg;
    logic          rd_valid_reg;
    logic          a_valid_reg, a_valid_next;
    logic          hit_reg;
    logic          end_reg;

    // operation registers
    logic                  set_reg;
    logic [10:0]           len_reg;
    logic [10:0]           r_reg;
    logic [AW-1:0]         s_word_reg, e_word_reg;
    logic [WORD_IDX_W-1:0] s_bit_reg, e_bit_reg;
    logic [9:0]            pos_reg;
    logic                  err_reg;

    // read and scan pipeline
    logic [AW-1:0]         rd_addr_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic [AW-1:0]         a_tag_reg;
    logic [WORD_BITS-1:0]  a_free_reg;
    logic [5:0]            a_runw_reg [WORD_BITS];
    logic [5:0]            runw [WORD_BITS];
    logic [WORD_BITS-1:0]  free_v;

    // stage B
    logic [WORD_BITS-1:0]  hit_v;
    logic [WORD_IDX_W-1:0] jsel;
    logic                  scan_active;
    logic [PW-1:0]         pos_full;

    // read-modify-write
    logic [WORD_BITS-1:0]  lo_mask, hi_mask, wmask, wdata;
    logic                  wr_en;

    assign sum       = 12'(start_bit) + 12'(run_length);
    assign e_last    = sum - 12'd1;
    assign range_bad = {4'b0, sum} > MAP_BITS_V;
    assign len_zero  = (run_length == 11'd0);
    assign len_big   = {5'b0, run_length} > MAP_BITS_V;
    assign is_rmw    = (func == FUNC_ALLOC) || (func == FUNC_FREE);

    assign st.go_scan   = (func == FUNC_SEARCH) && !len_zero && !len_big;
    assign st.go_rmw    = is_rmw && !range_bad && !len_zero;
    assign st.addr_last = (addr_reg == last_reg);
    assign st.hit       = hit_reg;
    assign st.scan_end  = end_reg;

    // word address counter
    always_comb
    begin
        addr_next = addr_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            if (st.go_rmw)
            begin
                addr_next = AW'(start_bit[9:5]);
                last_next = AW'(e_last[11:5]);
            end
            else
            begin
                addr_next = '0;
                last_next = LAST_WORD;
            end
        end
        else if (cmd.rd || cmd.clr_wr)
        begin
            addr_next = addr_reg + AW'(1);
        end
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mem[addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[rd_addr_reg] <= wdata;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_addr_reg <= addr_reg;
        end
    end

    // stage A: run of free bits ending at each position within the word,
    // via a prefix max of (index+1) over set bits
    always_comb
    begin
        logic [5:0] pm [6][WORD_BITS];
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (rd_data_reg[j] || ((TAIL != 0) && (rd_addr_reg == LAST_WORD) && (j >= TAIL)))
            begin
                pm[0][j] = 6'(j + 1);
            end
            else
            begin
                pm[0][j] = 6'd0;
            end
        end
        for (int l = 0; l < WORD_IDX_W; l++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                pm[l+1][j] = pm[l][j];
                if (j >= (1 << l))
                begin
                    if (pm[l][j - (1 << l)] > pm[l][j])
                    begin
                        pm[l+1][j] = pm[l][j - (1 << l)];
                    end
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            runw[j]   = 6'(j + 1) - pm[WORD_IDX_W][j];
            free_v[j] = (pm[WORD_IDX_W][j] == 6'd0);
        end
    end

    assign a_valid_next = cmd.load ? 1'b0 : (rd_valid_reg && !rmw_reg);

    always_ff @(posedge clk)
    begin
        a_tag_reg  <= rd_addr_reg;
        a_free_reg <= free_v;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            a_runw_reg[j] <= runw[j];
        end
    end

    // stage B: r_reg is the run length still needed beyond the carried run
    always_comb
    begin
        jsel = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            hit_v[j] = (a_free_reg[j] && (11'(j + 1) >= r_reg)) ||
                       (11'(a_runw_reg[j]) >= len_reg);
        end
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                jsel = WORD_IDX_W'(j);
            end
        end
    end

    assign scan_active = a_valid_reg && !hit_reg && !end_reg;
    assign pos_full    = PW'({a_tag_reg, jsel}) + PW'(1) - PW'(len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            last_reg     <= LAST_WORD;
            rmw_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            end_reg      <= 1'b0;
        end
        else
        begin
            addr_reg     <= addr_next;
            last_reg     <= last_next;
            rd_valid_reg <= cmd.rd;
            a_valid_reg  <= a_valid_next;
            if (cmd.load)
            begin
                rmw_reg <= st.go_rmw;
                hit_reg <= 1'b0;
                end_reg <= 1'b0;
            end
            else if (scan_active)
            begin
                if (|hit_v)
                begin
                    hit_reg <= 1'b1;
                end
                else if (a_tag_reg == LAST_WORD)
                begin
                    end_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg    <= (func == FUNC_ALLOC);
            len_reg    <= run_length;
            r_reg      <= run_length;
            s_word_reg <= AW'(start_bit[9:5]);
            s_bit_reg  <= start_bit[4:0];
            e_word_reg <= AW'(e_last[11:5]);
            e_bit_reg  <= e_last[4:0];
            pos_reg    <= '0;
            err_reg    <= is_rmw && range_bad;
        end
        else if (scan_active)
        begin
            if (|hit_v)
            begin
                pos_reg <= pos_full[9:0];
            end
            else if (a_free_reg[WORD_BITS-1])
            begin
                r_reg <= r_reg - 11'(WORD_BITS);
            end
            else
            begin
                r_reg <= len_reg - 11'(a_runw_reg[WORD_BITS-1]);
            end
        end
    end

    // range mask for the word just read
    assign lo_mask = (rd_addr_reg == s_word_reg) ? ({WORD_BITS{1'b1}} << s_bit_reg)
                                                 : {WORD_BITS{1'b1}};
    assign hi_mask = (rd_addr_reg == e_word_reg)
                   ? ({WORD_BITS{1'b1}} >> (WORD_IDX_W'(WORD_BITS - 1) - e_bit_reg))
                   : {WORD_BITS{1'b1}};
    assign wmask   = lo_mask & hi_mask;
    assign wdata   = set_reg ? (rd_data_reg | wmask) : (rd_data_reg & ~wmask);
    assign wr_en   = rd_valid_reg && rmw_reg;

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            found       <= hit_reg;
            run_start   <= pos_reg;
            range_error <= err_reg;
        end
    end

endmodule

// File: rtl/bitmap_first_fit_allocator_core.sv
// Search: one 32-bit bitmap word read per cycle (MAP_BYTES/4 words, 32 by default), two
//   scan stages, then the output register; a fit found early ends the scan sooner.
// Allocate/free: read-modify-write of the touched words; errors, zero lengths and unused
//   codes skip it. One request in flight; next accept in the result cycle.
// Reset clears all MAP_BYTES/4 bitmap words in a sweep; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core
// Allocation bitmap with first-fit free run search and range set/clear.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_core #(
    parameter int MAP_BYTES = bffa_pkg::MAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bffa_req_if.sink    req,
    bffa_rsp_if.source  rsp
);
    import bffa_pkg::*;

    bffa_cmd_t  cmd;
    bffa_stat_t st;

    bffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    bffa_dp #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .func        (req.func),
        .start_bit   (req.start_bit),
        .run_length  (req.run_length),
        .found       (rsp.found),
        .run_start   (rsp.run_start),
        .range_error (rsp.range_error)
    );

endmodule

// File: rtl/bffa_chk.sv
// ----------------------------------------------------------------------------
// bffa_chk
// Port-level checks for the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module bffa_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_found,
    input logic [9:0] rsp_run_start,
    input logic       rsp_range_error
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_run_start)
                                    && $stable(rsp_range_error))
        else $error("result payload changed while stalled");

    // a miss or a range operation reports start zero, never both flags
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_run_start == 10'd0)
        else $error("nonzero start without a fit");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_found && rsp_range_error))
        else $error("found and range error both set");

    // one request at a time: a transfer closes the request side
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

endmodule

bind bitmap_first_fit_allocator_core bffa_chk u_bffa_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_run_start   (rsp.run_start),
    .rsp_range_error (rsp.range_error)
);
